>>> design/cna_pkg.sv
// Shared types, action codes and default sizes for the complex number ALU.
`default_nettype none
package cna_pkg;

    localparam int unsigned FIELD_W        = 32;
    localparam int unsigned DEF_DATA_WIDTH = 32;
    localparam int unsigned DEF_FRAC_BITS  = 16;

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_EQ  = 3'd4;
    localparam logic [2:0] ACT_NE  = 3'd5;

    typedef struct packed {
        logic [2:0]                action;
        logic signed [FIELD_W-1:0] a_re;
        logic signed [FIELD_W-1:0] a_im;
        logic signed [FIELD_W-1:0] b_re;
        logic signed [FIELD_W-1:0] b_im;
    } cna_in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] res_re;
        logic signed [FIELD_W-1:0] res_im;
        logic                      compare_true;
        logic                      divide_by_zero;
        logic                      overflow;
    } cna_out_t;

    // control that travels with a beat down the divider chain
    typedef struct packed {
        logic is_div;
        logic dz;
        logic neg_re;
        logic neg_im;
        logic ovq_re;
        logic ovq_im;
        logic cmp;
        logic ovf;
    } cna_ctl_t;

endpackage
`default_nettype wire

>>> design/cna_front.sv
// Front end: products, sums, add, subtract and compare results, multiply results and divider set-up.
`default_nettype none
module cna_front
    import cna_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire cna_in_t                       s_data,
    output      logic                          o_valid,
    input  wire logic                          o_ready,
    output      cna_ctl_t                      o_ctl,
    output      logic signed [FIELD_W-1:0]     o_res_re,
    output      logic signed [FIELD_W-1:0]     o_res_im,
    output      logic [2*DATA_WIDTH-1:0]       o_den,
    output      logic [2*DATA_WIDTH-1:0]       o_rem_re,
    output      logic [2*DATA_WIDTH-1:0]       o_rem_im,
    output      logic [DATA_WIDTH-1:0]         o_xl_re,
    output      logic [DATA_WIDTH-1:0]         o_xl_im
);

    localparam int unsigned DW = DATA_WIDTH;
    localparam int unsigned MW = 2 * DATA_WIDTH;
    localparam int unsigned SW = 2 * DATA_WIDTH + 1;
    localparam int unsigned XW = 2 * DATA_WIDTH + FRAC_BITS;
    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    logic en1, en2, en3;

    // stage 1
    logic                      v1_reg;
    logic [2:0]                act1_reg;
    logic signed [MW-1:0]      p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, d_rr_reg, d_ii_reg;
    logic signed [FIELD_W-1:0] r1_re_reg, r1_im_reg;
    logic                      cmp1_reg, ovf1_reg;

    logic signed [DW-1:0]      ar, ai, br, bi;
    logic signed [DW:0]        sum_re, sum_im;
    logic signed [DW-1:0]      sat_re, sat_im;
    logic                      fit_re, fit_im;
    logic signed [FIELD_W-1:0] r1_re_next, r1_im_next;
    logic                      cmp1_next, ovf1_next;

    // stage 2
    logic                      v2_reg;
    logic [2:0]                act2_reg;
    logic signed [SW-1:0]      s_re_reg, s_im_reg;
    logic [MW-1:0]             den2_reg;
    logic signed [FIELD_W-1:0] r2_re_reg, r2_im_reg;
    logic                      cmp2_reg, ovf2_reg;

    // stage 3
    logic                      v3_reg;
    logic signed [SW-1:0]      sh_re, sh_im, neg_s_re, neg_s_im;
    logic [SW-DW:0]            hi_re, hi_im;
    logic                      mfit_re, mfit_im;
    logic signed [DW-1:0]      msat_re, msat_im;
    logic [MW-1:0]             mag_re, mag_im;
    logic [XW-1:0]             x_re, x_im, r0_re, r0_im;
    logic                      ovq_re, ovq_im;
    cna_ctl_t                  ctl_next;
    logic signed [FIELD_W-1:0] res_re_next, res_im_next;

    assign en3     = !v3_reg || o_ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign o_valid = v3_reg;

    assign ar = s_data.a_re[DW-1:0];
    assign ai = s_data.a_im[DW-1:0];
    assign br = s_data.b_re[DW-1:0];
    assign bi = s_data.b_im[DW-1:0];

    always_comb begin
        if (s_data.action == ACT_SUB) begin
            sum_re = {ar[DW-1], ar} - {br[DW-1], br};
            sum_im = {ai[DW-1], ai} - {bi[DW-1], bi};
        end else begin
            sum_re = {ar[DW-1], ar} + {br[DW-1], br};
            sum_im = {ai[DW-1], ai} + {bi[DW-1], bi};
        end
        fit_re = sum_re[DW] == sum_re[DW-1];
        fit_im = sum_im[DW] == sum_im[DW-1];
        sat_re = fit_re ? sum_re[DW-1:0] : (sum_re[DW] ? MINV : MAXV);
        sat_im = fit_im ? sum_im[DW-1:0] : (sum_im[DW] ? MINV : MAXV);
        r1_re_next = '0;
        r1_im_next = '0;
        cmp1_next  = 1'b0;
        ovf1_next  = 1'b0;
        case (s_data.action)
            ACT_ADD, ACT_SUB: begin
                r1_re_next = FIELD_W'(sat_re);
                r1_im_next = FIELD_W'(sat_im);
                ovf1_next  = !fit_re || !fit_im;
            end
            ACT_EQ:  cmp1_next = (ar == br) && (ai == bi);
            ACT_NE:  cmp1_next = (ar != br) || (ai != bi);
            default: cmp1_next = 1'b0;
        endcase
    end

    always_comb begin
        sh_re    = s_re_reg >>> FRAC_BITS;
        sh_im    = s_im_reg >>> FRAC_BITS;
        hi_re    = sh_re[SW-1:DW-1];
        hi_im    = sh_im[SW-1:DW-1];
        mfit_re  = (&hi_re) || !(|hi_re);
        mfit_im  = (&hi_im) || !(|hi_im);
        msat_re  = mfit_re ? sh_re[DW-1:0] : (sh_re[SW-1] ? MINV : MAXV);
        msat_im  = mfit_im ? sh_im[DW-1:0] : (sh_im[SW-1] ? MINV : MAXV);
        neg_s_re = -s_re_reg;
        neg_s_im = -s_im_reg;
        mag_re   = s_re_reg[SW-1] ? neg_s_re[MW-1:0] : s_re_reg[MW-1:0];
        mag_im   = s_im_reg[SW-1] ? neg_s_im[MW-1:0] : s_im_reg[MW-1:0];
        x_re     = XW'(mag_re) << FRAC_BITS;
        x_im     = XW'(mag_im) << FRAC_BITS;
        r0_re    = x_re >> DW;
        r0_im    = x_im >> DW;
        // quotient would not fit in DW bits: saturate without dividing
        ovq_re   = r0_re >= XW'(den2_reg);
        ovq_im   = r0_im >= XW'(den2_reg);

        ctl_next        = '0;
        ctl_next.is_div = act2_reg == ACT_DIV;
        ctl_next.dz     = den2_reg == '0;
        ctl_next.neg_re = s_re_reg[SW-1];
        ctl_next.neg_im = s_im_reg[SW-1];
        ctl_next.ovq_re = ovq_re;
        ctl_next.ovq_im = ovq_im;
        ctl_next.cmp    = cmp2_reg;
        ctl_next.ovf    = ovf2_reg;
        res_re_next     = r2_re_reg;
        res_im_next     = r2_im_reg;
        if (act2_reg == ACT_MUL) begin
            res_re_next  = FIELD_W'(msat_re);
            res_im_next  = FIELD_W'(msat_im);
            ctl_next.ovf = !mfit_re || !mfit_im;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            act1_reg  <= s_data.action;
            p_rr_reg  <= ar * br;
            p_ii_reg  <= ai * bi;
            p_ri_reg  <= ar * bi;
            p_ir_reg  <= ai * br;
            d_rr_reg  <= br * br;
            d_ii_reg  <= bi * bi;
            r1_re_reg <= r1_re_next;
            r1_im_reg <= r1_im_next;
            cmp1_reg  <= cmp1_next;
            ovf1_reg  <= ovf1_next;
        end
        if (en2) begin
            act2_reg <= act1_reg;
            if (act1_reg == ACT_DIV) begin
                s_re_reg <= SW'(p_rr_reg) + SW'(p_ii_reg);
                s_im_reg <= SW'(p_ir_reg) - SW'(p_ri_reg);
            end else begin
                s_re_reg <= SW'(p_rr_reg) - SW'(p_ii_reg);
                s_im_reg <= SW'(p_ri_reg) + SW'(p_ir_reg);
            end
            den2_reg  <= d_rr_reg[MW-1:0] + d_ii_reg[MW-1:0];
            r2_re_reg <= r1_re_reg;
            r2_im_reg <= r1_im_reg;
            cmp2_reg  <= cmp1_reg;
            ovf2_reg  <= ovf1_reg;
        end
        if (en3) begin
            o_ctl    <= ctl_next;
            o_res_re <= res_re_next;
            o_res_im <= res_im_next;
            o_den    <= den2_reg;
            o_rem_re <= ovq_re ? '0 : r0_re[MW-1:0];
            o_rem_im <= ovq_im ? '0 : r0_im[MW-1:0];
            o_xl_re  <= x_re[DW-1:0];
            o_xl_im  <= x_im[DW-1:0];
        end
    end

endmodule
`default_nettype wire

>>> design/cna_cell.sv
// One restoring-division cell: one quotient bit per lane, real and imaginary.
`default_nettype none
module cna_cell
    import cna_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      i_valid,
    output      logic                      i_ready,
    input  wire cna_ctl_t                  i_ctl,
    input  wire logic signed [FIELD_W-1:0] i_res_re,
    input  wire logic signed [FIELD_W-1:0] i_res_im,
    input  wire logic [2*DATA_WIDTH-1:0]   i_den,
    input  wire logic [2*DATA_WIDTH-1:0]   i_rem_re,
    input  wire logic [2*DATA_WIDTH-1:0]   i_rem_im,
    input  wire logic [DATA_WIDTH-1:0]     i_xl_re,
    input  wire logic [DATA_WIDTH-1:0]     i_xl_im,
    input  wire logic [DATA_WIDTH-1:0]     i_q_re,
    input  wire logic [DATA_WIDTH-1:0]     i_q_im,
    output      logic                      o_valid,
    input  wire logic                      o_ready,
    output      cna_ctl_t                  o_ctl,
    output      logic signed [FIELD_W-1:0] o_res_re,
    output      logic signed [FIELD_W-1:0] o_res_im,
    output      logic [2*DATA_WIDTH-1:0]   o_den,
    output      logic [2*DATA_WIDTH-1:0]   o_rem_re,
    output      logic [2*DATA_WIDTH-1:0]   o_rem_im,
    output      logic [DATA_WIDTH-1:0]     o_xl_re,
    output      logic [DATA_WIDTH-1:0]     o_xl_im,
    output      logic [DATA_WIDTH-1:0]     o_q_re,
    output      logic [DATA_WIDTH-1:0]     o_q_im
);

    localparam int unsigned DW = DATA_WIDTH;
    localparam int unsigned MW = 2 * DATA_WIDTH;

    logic          v_reg, en;
    logic [MW:0]   t_re, t_im, d_re, d_im;
    logic          ge_re, ge_im;

    assign en      = !v_reg || o_ready;
    assign i_ready = en;
    assign o_valid = v_reg;

    always_comb begin
        t_re  = {i_rem_re, i_xl_re[DW-1]};
        t_im  = {i_rem_im, i_xl_im[DW-1]};
        ge_re = t_re >= {1'b0, i_den};
        ge_im = t_im >= {1'b0, i_den};
        d_re  = t_re - {1'b0, i_den};
        d_im  = t_im - {1'b0, i_den};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= i_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_ctl    <= i_ctl;
            o_res_re <= i_res_re;
            o_res_im <= i_res_im;
            o_den    <= i_den;
            o_rem_re <= ge_re ? d_re[MW-1:0] : t_re[MW-1:0];
            o_rem_im <= ge_im ? d_im[MW-1:0] : t_im[MW-1:0];
            o_xl_re  <= {i_xl_re[DW-2:0], 1'b0};
            o_xl_im  <= {i_xl_im[DW-2:0], 1'b0};
            o_q_re   <= {i_q_re[DW-2:0], ge_re};
            o_q_im   <= {i_q_im[DW-2:0], ge_im};
        end
    end

endmodule
`default_nettype wire

>>> design/cna_back.sv
// Back end: signs and saturates quotients and holds the result register.
`default_nettype none
module cna_back
    import cna_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      i_valid,
    output      logic                      i_ready,
    input  wire cna_ctl_t                  i_ctl,
    input  wire logic signed [FIELD_W-1:0] i_res_re,
    input  wire logic signed [FIELD_W-1:0] i_res_im,
    input  wire logic [DATA_WIDTH-1:0]     i_q_re,
    input  wire logic [DATA_WIDTH-1:0]     i_q_im,
    output      logic                      m_valid,
    input  wire logic                      m_ready,
    output      cna_out_t                  m_data
);

    localparam int unsigned DW = DATA_WIDTH;
    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    logic                 v_reg, en;
    logic                 sat_re, sat_im;
    logic signed [DW-1:0] q_re, q_im;
    cna_out_t             out_next;

    assign en      = !v_reg || m_ready;
    assign i_ready = en;
    assign m_valid = v_reg;

    always_comb begin
        if (i_ctl.neg_re) begin
            sat_re = i_ctl.ovq_re || (i_q_re[DW-1] && (|i_q_re[DW-2:0]));
            q_re   = sat_re ? MINV : -i_q_re;
        end else begin
            sat_re = i_ctl.ovq_re || i_q_re[DW-1];
            q_re   = sat_re ? MAXV : i_q_re;
        end
        if (i_ctl.neg_im) begin
            sat_im = i_ctl.ovq_im || (i_q_im[DW-1] && (|i_q_im[DW-2:0]));
            q_im   = sat_im ? MINV : -i_q_im;
        end else begin
            sat_im = i_ctl.ovq_im || i_q_im[DW-1];
            q_im   = sat_im ? MAXV : i_q_im;
        end
        out_next.res_re         = i_res_re;
        out_next.res_im         = i_res_im;
        out_next.compare_true   = i_ctl.cmp;
        out_next.divide_by_zero = 1'b0;
        out_next.overflow       = i_ctl.ovf;
        if (i_ctl.is_div) begin
            if (i_ctl.dz) begin
                out_next.res_re         = '0;
                out_next.res_im         = '0;
                out_next.divide_by_zero = 1'b1;
                out_next.overflow       = 1'b0;
            end else begin
                out_next.res_re   = FIELD_W'(q_re);
                out_next.res_im   = FIELD_W'(q_im);
                out_next.overflow = sat_re || sat_im;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= i_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data <= out_next;
        end
    end

endmodule
`default_nettype wire

>>> design/complex_number_alu_top.sv
// Top level of the complex number ALU: front end, divider cell chain, back end.
`default_nettype none
// Complex arithmetic on two signed fixed-point operands (Q16.16 by default):
// add, subtract, multiply, divide, equal and not-equal test. Every beat takes
// one action and gives one result beat. The block accepts one beat per clock
// while m_ready does not hold the output back. The path has three front-end
// stages (six registered multipliers, the exact sums, then rounding of
// products and set-up of the division), one cell per quotient bit in the
// restoring divider chain, and the output register. All actions travel the
// same path, so results leave in order. Each stage holds its beat only while
// it is full and the next stage cannot take it, so bubbles close up and a new
// beat can be taken while a finished result waits at the output. Products
// round toward minus infinity; quotients truncate toward zero; parts that do
// not fit saturate and raise overflow.
// A zero divisor magnitude gives a zero result with divide_by_zero set.
module complex_number_alu_top
    import cna_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output      logic     s_ready,
    input  wire cna_in_t  s_data,
    output      logic     m_valid,
    input  wire logic     m_ready,
    output      cna_out_t m_data
);

    localparam int unsigned DW = DATA_WIDTH;
    localparam int unsigned MW = 2 * DATA_WIDTH;
    localparam logic signed [FIELD_W-1:0] MAXV = FIELD_W'({1'b0, {(DW-1){1'b1}}});
    localparam logic signed [FIELD_W-1:0] MINV = FIELD_W'(signed'({1'b1, {(DW-1){1'b0}}}));

    // chain taps: index 0 is the front end's output, index DW feeds the back end
    logic                      c_valid  [0:DW];
    logic                      c_ready  [0:DW];
    cna_ctl_t                  c_ctl    [0:DW];
    logic signed [FIELD_W-1:0] c_res_re [0:DW];
    logic signed [FIELD_W-1:0] c_res_im [0:DW];
    logic [MW-1:0]             c_den    [0:DW];
    logic [MW-1:0]             c_rem_re [0:DW];
    logic [MW-1:0]             c_rem_im [0:DW];
    logic [DW-1:0]             c_xl_re  [0:DW];
    logic [DW-1:0]             c_xl_im  [0:DW];
    logic [DW-1:0]             c_q_re   [0:DW];
    logic [DW-1:0]             c_q_im   [0:DW];

    cna_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .o_valid  (c_valid[0]),
        .o_ready  (c_ready[0]),
        .o_ctl    (c_ctl[0]),
        .o_res_re (c_res_re[0]),
        .o_res_im (c_res_im[0]),
        .o_den    (c_den[0]),
        .o_rem_re (c_rem_re[0]),
        .o_rem_im (c_rem_im[0]),
        .o_xl_re  (c_xl_re[0]),
        .o_xl_im  (c_xl_im[0])
    );

    // quotient starts empty; each cell shifts in one bit
    assign c_q_re[0] = '0;
    assign c_q_im[0] = '0;

    for (genvar i = 0; i < DW; i++) begin : g_cell
        cna_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .i_valid  (c_valid[i]),
            .i_ready  (c_ready[i]),
            .i_ctl    (c_ctl[i]),
            .i_res_re (c_res_re[i]),
            .i_res_im (c_res_im[i]),
            .i_den    (c_den[i]),
            .i_rem_re (c_rem_re[i]),
            .i_rem_im (c_rem_im[i]),
            .i_xl_re  (c_xl_re[i]),
            .i_xl_im  (c_xl_im[i]),
            .i_q_re   (c_q_re[i]),
            .i_q_im   (c_q_im[i]),
            .o_valid  (c_valid[i+1]),
            .o_ready  (c_ready[i+1]),
            .o_ctl    (c_ctl[i+1]),
            .o_res_re (c_res_re[i+1]),
            .o_res_im (c_res_im[i+1]),
            .o_den    (c_den[i+1]),
            .o_rem_re (c_rem_re[i+1]),
            .o_rem_im (c_rem_im[i+1]),
            .o_xl_re  (c_xl_re[i+1]),
            .o_xl_im  (c_xl_im[i+1]),
            .o_q_re   (c_q_re[i+1]),
            .o_q_im   (c_q_im[i+1])
        );
    end

    cna_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .i_valid  (c_valid[DW]),
        .i_ready  (c_ready[DW]),
        .i_ctl    (c_ctl[DW]),
        .i_res_re (c_res_re[DW]),
        .i_res_im (c_res_im[DW]),
        .i_q_re   (c_q_re[DW]),
        .i_q_im   (c_q_im[DW]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef SYNTHESIS
    // a zero divisor forces a clean zero result
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.divide_by_zero |->
            m_data.res_re == '0 && m_data.res_im == '0 && !m_data.overflow)
        else $error("divide by zero beat carries a non-zero result");

    // a true compare outcome never comes with arithmetic flags or data
    a_cmp_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.compare_true |->
            !m_data.overflow && !m_data.divide_by_zero &&
            m_data.res_re == '0 && m_data.res_im == '0)
        else $error("compare beat carries arithmetic data");

    // overflow means at least one part sits at a range limit
    a_ovf_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflow |->
            m_data.res_re == MAXV || m_data.res_re == MINV ||
            m_data.res_im == MAXV || m_data.res_im == MINV)
        else $error("overflow flagged without a saturated part");
`endif

endmodule
`default_nettype wire
